@@ rtl/ilist_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilist_pkg
// Shared types and constants of the indexed list engine: request kinds,
// status codes, cell operations and the control word sent down the cell row.
// ----------------------------------------------------------------------------
package ilist_pkg;

  localparam int unsigned DEPTH_DEFAULT = 64;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned POS_W         = 7;
  localparam int unsigned LEN_W         = 7;

  typedef enum logic [2:0] {
    REQ_READ   = 3'd0,
    REQ_INSERT = 3'd1,
    REQ_UPDATE = 3'd2,
    REQ_DELETE = 3'd3,
    REQ_CLEAR  = 3'd4
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_UPDATE = 2'd2,
    CELL_DELETE = 2'd3
  } cell_op_t;

  typedef struct packed {
    logic                     load;   // item accepted: capture read taps
    cell_op_t                 op;
    logic [POS_W-1:0]         pos;    // target index of the operation
    logic [POS_W-1:0]         rd_pos; // index addressed by the request
    logic signed [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage

@@ rtl/ilist_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilist_cell
// One list slot: holds an entry, takes a neighbor's entry on insert or delete
// or the request value as the target, offers it on a read tap when addressed.
// ----------------------------------------------------------------------------
module ilist_cell #(
  parameter int unsigned INDEX = 0
) (
  input  logic                                clk,
  input  ilist_pkg::cell_ctrl_t               ctrl,
  input  logic signed [ilist_pkg::DATA_W-1:0] left_data,
  input  logic signed [ilist_pkg::DATA_W-1:0] right_data,
  output logic signed [ilist_pkg::DATA_W-1:0] entry,
  output logic signed [ilist_pkg::DATA_W-1:0] tap
);

  localparam logic [ilist_pkg::POS_W-1:0] IDX = ilist_pkg::POS_W'(INDEX);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      tap <= (ctrl.rd_pos == IDX) ? entry : '0;
    end
    case (ctrl.op)
      ilist_pkg::CELL_INSERT: begin
        // shift up above the insert point
        if (IDX > ctrl.pos) begin
          entry <= left_data;
        end else if (IDX == ctrl.pos) begin
          entry <= ctrl.value;
        end
      end
      ilist_pkg::CELL_UPDATE: begin
        if (IDX == ctrl.pos) begin
          entry <= ctrl.value;
        end
      end
      ilist_pkg::CELL_DELETE: begin
        // shift down from the deleted slot
        if (IDX >= ctrl.pos) begin
          entry <= right_data;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/ilist_chain.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilist_chain
// Row of DEPTH list cells linked to their neighbors, with the OR merge of the
// registered read taps.
// ----------------------------------------------------------------------------
module ilist_chain #(
  parameter int unsigned DEPTH = ilist_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  ilist_pkg::cell_ctrl_t               ctrl,
  output logic signed [ilist_pkg::DATA_W-1:0] rd_word
);

  logic signed [ilist_pkg::DATA_W-1:0] entries [DEPTH];
  logic signed [ilist_pkg::DATA_W-1:0] taps    [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam int unsigned LEFT  = (i == 0) ? 0 : i - 1;
    localparam int unsigned RIGHT = (i == DEPTH - 1) ? i : i + 1;
    ilist_cell #(
      .INDEX(i)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .left_data (entries[LEFT]),
      .right_data(entries[RIGHT]),
      .entry     (entries[i]),
      .tap       (taps[i])
    );
  end

  // at most one tap is nonzero
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_word = rd_word | taps[i];
    end
  end

endmodule

@@ rtl/indexed_list_insert_delete_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_insert_delete_core
// Ordered list of up to DEPTH signed entries kept in a row of cells. Serves
// read, insert, update, delete and clear requests, one result per request.
//
//   channel | valid     | stall     | fields
//   --------+-----------+-----------+------------------------------------
//   request | req_valid | req_stall | req_type, position, item_value
//   result  | rsp_valid | rsp_stall | status, read_data, list_length
//
// All cells shift in the cycle an item is accepted; one item per cycle is
// sustained while the result side takes items.
// The cells capture the addressed entry on their read taps, then the merged
// tap word and status load the result register.
// Reset clears the length and the handshake state; entries are not cleared.
// A stalled result holds; the request side stalls only when a finished item
// cannot move into the result register.
// ----------------------------------------------------------------------------
module indexed_list_insert_delete_core #(
  parameter int unsigned DEPTH = ilist_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  logic [2:0]                          req_type,
  input  logic [ilist_pkg::POS_W-1:0]         position,
  input  logic signed [ilist_pkg::DATA_W-1:0] item_value,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output logic [1:0]                          status,
  output logic signed [ilist_pkg::DATA_W-1:0] read_data,
  output logic [ilist_pkg::LEN_W-1:0]         list_length
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = ilist_pkg::POS_W + 1;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  logic                     pend_valid;
  ilist_pkg::status_t       pend_status;
  logic                     pend_rd_ok;
  logic [CNT_W-1:0]         pend_len;

  ilist_pkg::status_t       st_next;
  logic                     rd_ok_next;
  ilist_pkg::cell_ctrl_t    ctrl;
  logic signed [ilist_pkg::DATA_W-1:0] rd_word;

  logic accept;
  logic pend_move;
  logic in_range;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;

  assign pend_move = pend_valid && !(rsp_valid && rsp_stall);
  assign req_stall = pend_valid && !pend_move;
  assign accept    = req_valid && !req_stall;

  assign pos_ext  = CMP_W'(position);
  assign cnt_ext  = CMP_W'(count);
  assign in_range = pos_ext < cnt_ext;

  always_comb begin
    count_next   = count;
    st_next      = ilist_pkg::ST_OK;
    rd_ok_next   = 1'b0;
    ctrl.load    = accept;
    ctrl.op      = ilist_pkg::CELL_HOLD;
    ctrl.pos     = position;
    ctrl.rd_pos  = position;
    ctrl.value   = item_value;
    case (req_type)
      ilist_pkg::REQ_READ: begin
        if (in_range) begin
          rd_ok_next = 1'b1;
        end else begin
          st_next = ilist_pkg::ST_RANGE;
        end
      end
      ilist_pkg::REQ_INSERT: begin
        if (count == FULL_CNT) begin
          st_next = ilist_pkg::ST_FULL;
        end else begin
          ctrl.op    = ilist_pkg::CELL_INSERT;
          count_next = count + 1'b1;
          // clamp to append
          if (!in_range) begin
            ctrl.pos = ilist_pkg::POS_W'(count);
          end
        end
      end
      ilist_pkg::REQ_UPDATE: begin
        if (in_range) begin
          ctrl.op = ilist_pkg::CELL_UPDATE;
        end else begin
          st_next = ilist_pkg::ST_RANGE;
        end
      end
      ilist_pkg::REQ_DELETE: begin
        if (in_range) begin
          ctrl.op    = ilist_pkg::CELL_DELETE;
          count_next = count - 1'b1;
        end else begin
          st_next = ilist_pkg::ST_RANGE;
        end
      end
      ilist_pkg::REQ_CLEAR: begin
        count_next = '0;
      end
      default: begin
      end
    endcase
    if (!accept) begin
      ctrl.op    = ilist_pkg::CELL_HOLD;
      count_next = count;
    end
  end

  ilist_chain #(
    .DEPTH(DEPTH)
  ) u_chain (
    .clk    (clk),
    .ctrl   (ctrl),
    .rd_word(rd_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      pend_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        pend_valid <= 1'b1;
      end else if (pend_move) begin
        pend_valid <= 1'b0;
      end
      if (pend_move) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_status <= st_next;
      pend_rd_ok  <= rd_ok_next;
      pend_len    <= count_next;
    end
    if (pend_move) begin
      status      <= pend_status;
      read_data   <= pend_rd_ok ? rd_word : '0;
      list_length <= ilist_pkg::LEN_W'(pend_len);
    end
  end

endmodule

@@ rtl/ilist_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilist_chk
// Port-level checks of the indexed list engine, bound to the top level.
// ----------------------------------------------------------------------------
module ilist_chk #(
  parameter int unsigned DEPTH = ilist_pkg::DEPTH_DEFAULT
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                req_valid,
  input logic                                req_stall,
  input logic                                rsp_valid,
  input logic                                rsp_stall,
  input logic [1:0]                          status,
  input logic signed [ilist_pkg::DATA_W-1:0] read_data,
  input logic [ilist_pkg::LEN_W-1:0]         list_length
);

  localparam logic [ilist_pkg::LEN_W-1:0] FULL_LEN = ilist_pkg::LEN_W'(DEPTH);

  // hold a stalled result
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(read_data) && $stable(status))
    else $error("stalled result changed");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> list_length <= FULL_LEN)
    else $error("list length above depth");

  a_full_len: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ilist_pkg::ST_FULL |-> list_length == FULL_LEN)
    else $error("full status with list not full");

  a_err_data: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != ilist_pkg::ST_OK |-> read_data == '0)
    else $error("read data on failed request");

  // a request waiting while the result side is free must be taken
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_stall |-> rsp_valid && rsp_stall)
    else $error("request stalled with result side free");

endmodule

bind indexed_list_insert_delete_core ilist_chk #(.DEPTH(DEPTH)) u_ilist_chk (.*);
